// ===== design/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// shared types and constants of the round-trip time averager
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int TIME_W           = 31;
    localparam int SAMPLE_W         = 32;
    localparam int AVG_W            = 26;
    localparam int COUNT_W          = 4;
    localparam int FRAC_BITS        = 16;
    localparam int MS_PER_S         = 1000;

    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_PING  = 2'd1,
        CMD_PONG  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] event_time;
    } t_in_word;

    typedef struct packed {
        logic signed [AVG_W-1:0] average_ms;
        logic                    average_valid;
        logic [COUNT_W-1:0]      sample_count;
        logic                    pong_ignored;
    } t_out_word;

endpackage

// ===== design/rtt_window_average.sv =====
// ----------------------------------------------------------------------------
// rtt_window_average
// round-trip time averager over a ring of the most recent samples
// ----------------------------------------------------------------------------
// Each input word carries a command (reset window, ping sent, pong received)
// and a 15.16 timestamp; each input word gives exactly one status word
// (average in ms, valid flag, sample count, ignored-pong flag).
// Reset window, ping and ignored or unknown commands finish in the cycle they
// are taken; their status word goes through the pending register into the output
// register, and the next input word is taken once the pending register is empty.
// A pong that adds a sample reads the old ring entry, updates the running sum,
// takes its magnitude, scales it by 1000 and divides by the sample count in a
// serial divider: the ram read is issued on acceptance, then S_READ updates the
// sum, S_ABS takes the magnitude and S_MUL starts the divider, which takes
// 25 + $clog2(WINDOW_DEPTH) steps; the result then passes through the pending
// and output registers. The next input is taken once the pending register is
// empty again.
// A result waiting on a stalled receiver holds one more result in a pending
// register; input stalls while that register is full or a pong is in work.
// A synchronous reset empties the window, clears the ping and sets the
// average to -1; the sample ram is not cleared. Input stalls during reset.
// ----------------------------------------------------------------------------
module rtt_window_average #(
    parameter int WINDOW_DEPTH = rtt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rtt_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rtt_pkg::t_out_word o_out_data
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int HELD_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = rtt_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_W = SUM_W + 9;
    localparam int DIVD_W = PROD_W - rtt_pkg::FRAC_BITS;
    localparam int AVG_W  = rtt_pkg::AVG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ABS,
        S_MUL,
        S_DIV
    } t_state;

    t_state                        r_state, n_state;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic [HELD_W-1:0]             r_held, n_held;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [rtt_pkg::TIME_W-1:0]    r_start, n_start;
    logic                          r_ping, n_ping;
    logic signed [AVG_W-1:0]       r_avg, n_avg;
    logic                          r_pend_v, n_pend_v;
    rtt_pkg::t_out_word            r_pend, n_pend;
    logic                          r_out_v, n_out_v;
    rtt_pkg::t_out_word            r_out, n_out;
    logic signed [rtt_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic [MAG_W-1:0]              r_mag, n_mag;
    logic                          r_neg, n_neg;

    logic                          accept;
    logic                          full;
    logic                          pend_load;
    logic                          ignored;
    logic signed [rtt_pkg::SAMPLE_W-1:0] sample_c;
    logic signed [SUM_W-1:0]       old_ext;
    logic [SUM_W-1:0]              abs_full;
    logic [PROD_W-1:0]             prod;
    logic [31:0]                   held_ext;
    logic [DIVD_W-1:0]             quo;
    logic signed [AVG_W-1:0]       quo_avg;
    logic                          div_start;
    logic                          div_done;
    logic                          ram_wr_en;
    logic                          ram_rd_en;
    logic [rtt_pkg::SAMPLE_W-1:0]  ram_rd_data;

    rtt_ram #(
        .WIDTH (rtt_pkg::SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_sample),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_slot),
        .o_rd_data (ram_rd_data)
    );

    rtt_div #(
        .DIVD_W (DIVD_W),
        .DVSR_W (HELD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod[PROD_W-1:rtt_pkg::FRAC_BITS]),
        .i_divisor  (r_held),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || r_pend_v;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_held == HELD_W'(WINDOW_DEPTH));
    assign sample_c   = $signed({1'b0, i_in_data.event_time}) - $signed({1'b0, r_start});
    assign old_ext    = full ? SUM_W'($signed(ram_rd_data)) : '0;
    assign abs_full   = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign prod       = PROD_W'(r_mag) * PROD_W'(rtt_pkg::MS_PER_S);
    assign quo_avg    = r_neg ? -AVG_W'(quo) : AVG_W'(quo);

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_held    = r_held;
        n_sum     = r_sum;
        n_start   = r_start;
        n_ping    = r_ping;
        n_avg     = r_avg;
        n_sample  = r_sample;
        n_mag     = r_mag;
        n_neg     = r_neg;
        pend_load = 1'b0;
        ignored   = 1'b0;
        div_start = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.command)
                        rtt_pkg::CMD_RESET: begin
                            n_slot    = '0;
                            n_held    = '0;
                            n_sum     = '0;
                            n_start   = '0;
                            n_ping    = 1'b0;
                            n_avg     = '1;
                            pend_load = 1'b1;
                        end
                        rtt_pkg::CMD_PING: begin
                            n_start   = i_in_data.event_time;
                            n_ping    = 1'b1;
                            pend_load = 1'b1;
                        end
                        rtt_pkg::CMD_PONG: begin
                            if (!r_ping) begin
                                ignored   = 1'b1;
                                pend_load = 1'b1;
                            end else begin
                                // fetch the entry about to be overwritten
                                n_sample  = sample_c;
                                ram_rd_en = 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            pend_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_sum     = r_sum - old_ext + SUM_W'(r_sample);
                ram_wr_en = 1'b1;
                if (!full) begin
                    n_held = r_held + HELD_W'(1);
                end
                if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
                n_state = S_ABS;
            end
            S_ABS: begin
                // truncation toward zero: divide the magnitude, restore the sign later
                n_neg   = r_sum[SUM_W-1];
                n_mag   = abs_full[MAG_W-1:0];
                n_state = S_MUL;
            end
            S_MUL: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_avg     = quo_avg;
                    pend_load = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        held_ext = 32'(n_held);
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v;
        n_out    = r_out;
        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end
        if (r_pend_v && (!r_out_v || !i_out_stall)) begin
            n_out_v  = 1'b1;
            n_out    = r_pend;
            n_pend_v = 1'b0;
        end
        if (pend_load) begin
            n_pend_v             = 1'b1;
            n_pend.average_ms    = n_avg;
            n_pend.average_valid = (n_held != '0);
            n_pend.sample_count  = held_ext[rtt_pkg::COUNT_W-1:0];
            n_pend.pong_ignored  = ignored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_held   <= '0;
            r_sum    <= '0;
            r_start  <= '0;
            r_ping   <= 1'b0;
            r_avg    <= '1;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_held   <= n_held;
            r_sum    <= n_sum;
            r_start  <= n_start;
            r_ping   <= n_ping;
            r_avg    <= n_avg;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend   <= n_pend;
        r_out    <= n_out;
        r_sample <= n_sample;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_accept_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input taken while previous word still in flight");

    a_pend_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !r_out_v) |=> r_out_v)
        else $error("pending word not moved to free output register");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(WINDOW_DEPTH))
        else $error("sample count beyond window depth");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_pong_valid_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |=> (r_pend_v && r_pend.average_valid))
        else $error("completed pong without a valid average");
`endif

endmodule

// ===== design/rtt_ram.sv =====
// ----------------------------------------------------------------------------
// rtt_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module rtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/rtt_div.sv =====
// ----------------------------------------------------------------------------
// rtt_div
// serial restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module rtt_div #(
    parameter int DIVD_W = 28,
    parameter int DVSR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DVSR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DVSR_W-1:0] r_rem, n_rem;
    logic [DVSR_W-1:0] r_dvsr, n_dvsr;
    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W:0]   rem_diff;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_step   = r_step;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvsr   = r_dvsr;
        rem_sh   = {r_rem, r_quo[DIVD_W-1]};
        rem_diff = rem_sh - {1'b0, r_dvsr};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(DIVD_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvsr = i_divisor;
        end else if (r_busy) begin
            // shift the next dividend bit into the remainder, quotient bit fills from below
            if (!rem_diff[DVSR_W]) begin
                n_rem = rem_diff[DVSR_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DVSR_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b0};
            end
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvsr <= n_dvsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
